/* rtl/core/ist_pkg.sv */
// Package for the indexed shift table: sizes, operation and status codes,
// controller states and the structs passed between the table's modules.
// Has no dependencies.
package ist_pkg;

	localparam int DEPTH       = 64;
	localparam int ENTRY_WIDTH = 32;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int OP_W        = 3;
	localparam int IDX_W       = 7;
	localparam int DATA_W      = 32;
	localparam int STAT_W      = 2;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_READ   = 3'd2,
		OP_INSERT = 3'd3,
		OP_REMOVE = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_BOUNDS = 2'd1,
		STAT_FULL   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_FETCH,
		S_MOVE_RD,
		S_MOVE_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                   we;
		logic [ADDR_W-1:0]      waddr;
		logic [ENTRY_WIDTH-1:0] wdata;
		logic [ADDR_W-1:0]      raddr;
	} ram_req_t;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  count;
	} res_t;

endpackage

/* rtl/core/ist_ram.sv */
// Entry memory of the indexed shift table: one write port and one read port
// with a registered read. Generic; no package dependency.
module ist_ram #(
	parameter int AW = 6,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/ist_seq.sv */
// Sequencer of the indexed shift table: holds the count, decodes each beat
// and walks the entry memory one entry at a time. Depends on ist_pkg.
module ist_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ist_pkg::OP_W-1:0]            op,
	input  logic [ist_pkg::IDX_W-1:0]           index,
	input  logic [ist_pkg::DATA_W-1:0]          data_in,
	output logic                                res_valid,
	input  logic                                res_take,
	output ist_pkg::res_t                       res,
	output ist_pkg::ram_req_t                   ram_req,
	input  logic [ist_pkg::ENTRY_WIDTH-1:0]     ram_rdata
);

	ist_pkg::state_t                     state_q, state_d;
	ist_pkg::op_t                        op_q, op_d;
	logic [ist_pkg::IDX_W-1:0]           idx_q, idx_d;
	logic [ist_pkg::ENTRY_WIDTH-1:0]     din_q, din_d;
	logic [ist_pkg::CNT_W-1:0]           cnt_q, cnt_d;
	logic [ist_pkg::CNT_W-1:0]           ptr_q, ptr_d;
	ist_pkg::status_t                    stat_q, stat_d;
	logic [ist_pkg::DATA_W-1:0]          dout_q, dout_d;
	logic [ist_pkg::CNT_W-1:0]           ptr_dn, ptr_up, cnt_dn;

	assign ptr_dn = ptr_q - 1'b1;
	assign ptr_up = ptr_q + 1'b1;
	assign cnt_dn = cnt_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ist_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		idx_q  <= idx_d;
		din_q  <= din_d;
		ptr_q  <= ptr_d;
		stat_q <= stat_d;
		dout_q <= dout_d;
	end

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		idx_d     = idx_q;
		din_d     = din_q;
		cnt_d     = cnt_q;
		ptr_d     = ptr_q;
		stat_d    = stat_q;
		dout_d    = dout_q;
		ram_req   = '0;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ist_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op_d    = ist_pkg::op_t'(op);
					idx_d   = index;
					din_d   = data_in[ist_pkg::ENTRY_WIDTH-1:0];
					state_d = ist_pkg::S_EXEC;
				end
			end
			ist_pkg::S_EXEC: begin
				stat_d  = ist_pkg::STAT_OK;
				dout_d  = '0;
				state_d = ist_pkg::S_DONE;
				case (op_q)
					ist_pkg::OP_PUSH: begin
						if (cnt_q == ist_pkg::DEPTH_CNT) begin
							stat_d = ist_pkg::STAT_FULL;
						end else begin
							ram_req.we    = 1'b1;
							ram_req.waddr = cnt_q[ist_pkg::ADDR_W-1:0];
							ram_req.wdata = din_q;
							cnt_d         = cnt_q + 1'b1;
						end
					end
					ist_pkg::OP_POP: begin
						if (cnt_q == '0) begin
							stat_d = ist_pkg::STAT_BOUNDS;
						end else begin
							ram_req.raddr = cnt_dn[ist_pkg::ADDR_W-1:0];
							cnt_d         = cnt_dn;
							state_d       = ist_pkg::S_FETCH;
						end
					end
					ist_pkg::OP_READ: begin
						if (idx_q >= cnt_q) begin
							stat_d = ist_pkg::STAT_BOUNDS;
						end else begin
							ram_req.raddr = idx_q[ist_pkg::ADDR_W-1:0];
							state_d       = ist_pkg::S_FETCH;
						end
					end
					ist_pkg::OP_INSERT: begin
						if (idx_q > cnt_q) begin
							stat_d = ist_pkg::STAT_BOUNDS;
						end else if (cnt_q == ist_pkg::DEPTH_CNT) begin
							stat_d = ist_pkg::STAT_FULL;
						end else begin
							ptr_d   = cnt_q;
							cnt_d   = cnt_q + 1'b1;
							state_d = ist_pkg::S_MOVE_RD;
						end
					end
					ist_pkg::OP_REMOVE: begin
						if (idx_q >= cnt_q) begin
							stat_d = ist_pkg::STAT_BOUNDS;
						end else begin
							ram_req.raddr = idx_q[ist_pkg::ADDR_W-1:0];
							ptr_d         = idx_q;
							cnt_d         = cnt_dn;
							state_d       = ist_pkg::S_FETCH;
						end
					end
					ist_pkg::OP_CLEAR: begin
						cnt_d = '0;
					end
					default: begin
					end
				endcase
			end
			ist_pkg::S_FETCH: begin
				dout_d  = ist_pkg::DATA_W'(ram_rdata);
				state_d = (op_q == ist_pkg::OP_REMOVE) ? ist_pkg::S_MOVE_RD
					: ist_pkg::S_DONE;
			end
			ist_pkg::S_MOVE_RD: begin
				if (op_q == ist_pkg::OP_INSERT) begin
					if (ptr_q == idx_q) begin
						ram_req.we    = 1'b1;
						ram_req.waddr = idx_q[ist_pkg::ADDR_W-1:0];
						ram_req.wdata = din_q;
						state_d       = ist_pkg::S_DONE;
					end else begin
						ram_req.raddr = ptr_dn[ist_pkg::ADDR_W-1:0];
						state_d       = ist_pkg::S_MOVE_WR;
					end
				end else begin
					if (ptr_q == cnt_q) begin
						state_d = ist_pkg::S_DONE;
					end else begin
						ram_req.raddr = ptr_up[ist_pkg::ADDR_W-1:0];
						state_d       = ist_pkg::S_MOVE_WR;
					end
				end
			end
			ist_pkg::S_MOVE_WR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = ptr_q[ist_pkg::ADDR_W-1:0];
				ram_req.wdata = ram_rdata;
				ptr_d         = (op_q == ist_pkg::OP_INSERT) ? ptr_dn : ptr_up;
				state_d       = ist_pkg::S_MOVE_RD;
			end
			ist_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ist_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ist_pkg::S_IDLE;
			end
		endcase
	end

	assign res.status = stat_q;
	assign res.data   = dout_q;
	assign res.count  = cnt_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ist_pkg::DEPTH_CNT)
		else $error("count exceeds table depth");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ist_pkg::S_IDLE || state_q == ist_pkg::S_DONE) |-> !ram_req.we)
		else $error("memory written outside an operation");
	a_err_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status != ist_pkg::STAT_OK) |-> res.data == '0)
		else $error("error result carries data");
	a_move_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ist_pkg::S_MOVE_WR) |-> ptr_q < ist_pkg::DEPTH_CNT)
		else $error("shift pointer outside the table");
`endif

endmodule

/* rtl/core/indexed_shift_table_core.sv */
// Top level of the indexed shift table: sequencer, entry memory and the
// result output register. Depends on ist_pkg, ist_seq and ist_ram.
//
//   channel | direction | signals
//   input   | in        | in_valid, in_ready, op, index, data_in
//   result  | out       | out_valid, out_ready, status, data_out, count
//
// One item is worked at a time. Push, clear, refused and unused operations pass
// through S_EXEC and S_DONE; pop and read also pass through S_FETCH. Remove
// first fetches the removed entry; insert and remove move each shifted entry by
// reading it from the entry memory in S_MOVE_RD and writing it back in S_MOVE_WR.
// Reset clears the count, the state and the output valid; the memory keeps its
// contents. A stalled result stays in the output register, and the next beat is
// taken meanwhile but finishes only once the register frees.
module indexed_shift_table_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ist_pkg::OP_W-1:0]      op,
	input  logic [ist_pkg::IDX_W-1:0]     index,
	input  logic [ist_pkg::DATA_W-1:0]    data_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ist_pkg::STAT_W-1:0]    status,
	output logic [ist_pkg::DATA_W-1:0]    data_out,
	output logic [ist_pkg::CNT_W-1:0]     count
);

	ist_pkg::res_t                    res;
	ist_pkg::ram_req_t                ram_req;
	logic [ist_pkg::ENTRY_WIDTH-1:0]  ram_rdata;
	logic                             res_valid;
	logic                             res_take;
	logic                             out_valid_q;
	logic [ist_pkg::STAT_W-1:0]       status_q;
	logic [ist_pkg::DATA_W-1:0]       data_q;
	logic [ist_pkg::CNT_W-1:0]        count_q;

	ist_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.index     (index),
		.data_in   (data_in),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	ist_ram #(
		.AW (ist_pkg::ADDR_W),
		.DW (ist_pkg::ENTRY_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			status_q <= res.status;
			data_q   <= res.data;
			count_q  <= res.count;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data_out  = data_q;
	assign count     = count_q;

endmodule
